// ----- rtl/pswb_pkg.sv -----
// ----------------------------------------------------------------------------
// pswb_pkg
// Shared widths, constants, codes and types for the particle step with speed
// limit and wall bounce.
// ----------------------------------------------------------------------------
`default_nettype none

package pswb_pkg;

  // field widths
  localparam int POS_W   = 16;  // Q12.4 position
  localparam int VEL_W   = 14;  // signed Q6.8 velocity
  localparam int FORCE_W = 16;  // signed Q8.8 force
  localparam int IM_W    = 16;  // Q4.12 inverse mass
  localparam int DIM_W   = 12;  // arena size and radius
  localparam int HIT_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ARENA_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ARENA_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CIRCLE_RADIUS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INVERSE_MASS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_X      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y      = 3'd5;

  // register reset values
  localparam logic [DIM_W-1:0] ARENA_WIDTH_RST   = 12'd1024;
  localparam logic [DIM_W-1:0] ARENA_HEIGHT_RST  = 12'd768;
  localparam logic [DIM_W-1:0] CIRCLE_RADIUS_RST = 12'd320;
  localparam logic [IM_W-1:0]  INVERSE_MASS_RST  = 16'd4096;
  localparam logic [POS_W-1:0] START_X_RST       = 16'd8192;
  localparam logic [POS_W-1:0] START_Y_RST       = 16'd8192;

  // wall hit codes
  localparam logic [HIT_W-1:0] HIT_NONE = 2'd0;
  localparam logic [HIT_W-1:0] HIT_HIGH = 2'd1;  // right or bottom wall
  localparam logic [HIT_W-1:0] HIT_LOW  = 2'd2;  // left or top wall

  // speed limit in Q6.8
  localparam int MAX_SPEED = 20;
  localparam int LIM       = MAX_SPEED * 256;
  localparam int LIM_W     = 13;

  // working widths
  localparam int IM_FRAC    = 12;
  localparam int ROUND_HALF = 1 << (IM_FRAC - 1);
  localparam int VW         = 22;          // velocity after force add
  localparam int ABS_W      = VW - 1;      // magnitude of one component
  localparam int MUL_W      = 22;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int SQ_W       = 44;          // sum of squares
  localparam int ROOT_W     = SQ_W / 2;
  localparam int SQRT_STEPS = SQ_W / 2;
  localparam int Q_W        = LIM_W + 1;   // quotient never exceeds LIM
  localparam int D_W        = ABS_W + LIM_W;
  localparam int DIV_STEPS  = Q_W;
  localparam int CNT_W      = 5;

  // multiplier operand select
  localparam logic [1:0] MSEL_FX = 2'd0;
  localparam logic [1:0] MSEL_FY = 2'd1;
  localparam logic [1:0] MSEL_AX = 2'd2;
  localparam logic [1:0] MSEL_AY = 2'd3;

  typedef struct packed {
    logic [DIM_W-1:0] arena_width;
    logic [DIM_W-1:0] arena_height;
    logic [DIM_W-1:0] circle_radius;
    logic [IM_W-1:0]  inverse_mass;
    logic [POS_W-1:0] start_x;
    logic [POS_W-1:0] start_y;
  } cfg_t;

  typedef struct packed {
    logic       item_load;
    logic [1:0] mul_sel;
    logic       prod_load;
    logic       vx_load;
    logic       vy_load;
    logic       s_load;
    logic       s_add;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       div_init;
    logic       div_step;
    logic       cap_load;
    logic       step_commit;
    logic       restart_load;
  } cmd_t;

  typedef struct packed {
    logic capped;
  } sts_t;

  typedef struct packed {
    logic [POS_W-1:0]        pos;
    logic signed [VEL_W-1:0] vel;
    logic [HIT_W-1:0]        hit;
  } axis_t;

  // saturate to the velocity range
  function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [FORCE_W-1:0] v);
    logic signed [FORCE_W-1:0] vmax;
    logic signed [FORCE_W-1:0] vmin;
    vmax = FORCE_W'((1 << (VEL_W - 1)) - 1);
    vmin = -FORCE_W'(1 << (VEL_W - 1));
    if (v > vmax) begin
      return vmax[VEL_W-1:0];
    end else if (v < vmin) begin
      return vmin[VEL_W-1:0];
    end
    return v[VEL_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/pswb_item_if.sv -----
// ----------------------------------------------------------------------------
// pswb_item_if
// Input channel: one tick or restart word with valid and ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface pswb_item_if;
  import pswb_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      restart;
  logic signed [FORCE_W-1:0] force_x;
  logic signed [FORCE_W-1:0] force_y;

  modport source (output valid, output restart, output force_x, output force_y,
                  input ready);
  modport sink (input valid, input restart, input force_x, input force_y,
                output ready);
endinterface

`default_nettype wire

// ----- rtl/pswb_result_if.sv -----
// ----------------------------------------------------------------------------
// pswb_result_if
// Output channel: position, velocity and wall hits with valid and ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface pswb_result_if;
  import pswb_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [POS_W-1:0]        pos_x;
  logic [POS_W-1:0]        pos_y;
  logic signed [VEL_W-1:0] vel_x;
  logic signed [VEL_W-1:0] vel_y;
  logic [HIT_W-1:0]        hit_x;
  logic [HIT_W-1:0]        hit_y;

  modport source (output valid, output pos_x, output pos_y, output vel_x,
                  output vel_y, output hit_x, output hit_y, input ready);
  modport sink (input valid, input pos_x, input pos_y, input vel_x,
                input vel_y, input hit_x, input hit_y, output ready);
endinterface

`default_nettype wire

// ----- rtl/pswb_cfg_if.sv -----
// ----------------------------------------------------------------------------
// pswb_cfg_if
// Configuration write channel: register index and data with valid and ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface pswb_cfg_if;
  import pswb_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/pswb_cfg.sv -----
// ----------------------------------------------------------------------------
// pswb_cfg
// Configuration register file, written by index.
// ----------------------------------------------------------------------------
`default_nettype none

module pswb_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           wr_en,
  input  wire logic [pswb_pkg::CFG_IDX_W-1:0] wr_index,
  input  wire logic [pswb_pkg::CFG_DATA_W-1:0] wr_data,
  output pswb_pkg::cfg_t                      cfg
);
  import pswb_pkg::*;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.arena_width   <= ARENA_WIDTH_RST;
      cfg.arena_height  <= ARENA_HEIGHT_RST;
      cfg.circle_radius <= CIRCLE_RADIUS_RST;
      cfg.inverse_mass  <= INVERSE_MASS_RST;
      cfg.start_x       <= START_X_RST;
      cfg.start_y       <= START_Y_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_ARENA_WIDTH:   cfg.arena_width   <= wr_data[DIM_W-1:0];
        REG_ARENA_HEIGHT:  cfg.arena_height  <= wr_data[DIM_W-1:0];
        REG_CIRCLE_RADIUS: cfg.circle_radius <= wr_data[DIM_W-1:0];
        REG_INVERSE_MASS:  cfg.inverse_mass  <= wr_data[IM_W-1:0];
        REG_START_X:       cfg.start_x       <= wr_data[POS_W-1:0];
        REG_START_Y:       cfg.start_y       <= wr_data[POS_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pswb_div.sv -----
// ----------------------------------------------------------------------------
// pswb_div
// Restoring divider lane, one quotient bit per cycle while step is high. The quotient is known
// to fit in Q_W bits, so the upper dividend bits preload the remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module pswb_div (
  input  wire logic                        clk,
  input  wire logic                        init,
  input  wire logic                        step,
  input  wire logic [pswb_pkg::D_W-1:0]    dividend,
  input  wire logic [pswb_pkg::ROOT_W-1:0] divisor,
  output logic [pswb_pkg::Q_W-1:0]         quot
);
  import pswb_pkg::*;

  logic [ROOT_W-1:0] rem;
  logic [Q_W-1:0]    low;
  logic [ROOT_W:0]   trial;
  logic              fits;

  // shift in the next dividend bit and try the subtract
  assign trial = {rem, low[Q_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (init) begin
      rem  <= ROOT_W'(dividend >> Q_W);
      low  <= dividend[Q_W-1:0];
      quot <= '0;
    end else if (step) begin
      rem  <= fits ? ROOT_W'(trial - {1'b0, divisor}) : trial[ROOT_W-1:0];
      low  <= {low[Q_W-2:0], 1'b0};
      quot <= {quot[Q_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pswb_dp.sv -----
// ----------------------------------------------------------------------------
// pswb_dp
// Datapath: force scaling through a shared multiplier, sum of squares,
// digit-by-digit square root, two divider lanes for the speed cap, position
// update with wall clamp, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pswb_dp (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire pswb_pkg::cmd_t                      cmd,
  input  wire pswb_pkg::cfg_t                      cfg,
  input  wire logic signed [pswb_pkg::FORCE_W-1:0] item_force_x,
  input  wire logic signed [pswb_pkg::FORCE_W-1:0] item_force_y,
  output pswb_pkg::sts_t                           sts,
  output logic [pswb_pkg::POS_W-1:0]               pos_x,
  output logic [pswb_pkg::POS_W-1:0]               pos_y,
  output logic signed [pswb_pkg::VEL_W-1:0]        vel_x,
  output logic signed [pswb_pkg::VEL_W-1:0]        vel_y,
  output logic [pswb_pkg::HIT_W-1:0]               hit_x,
  output logic [pswb_pkg::HIT_W-1:0]               hit_y
);
  import pswb_pkg::*;

  localparam int REM_W = ROOT_W + 2;
  localparam int P_W   = POS_W + 3;

  // one axis: move, clamp at the walls and bounce
  function automatic axis_t wall_step(input logic [POS_W-1:0] pos,
                                      input logic signed [VW-1:0] v,
                                      input logic [DIM_W-1:0] dim,
                                      input logic [DIM_W-1:0] r);
    logic signed [VEL_W-1:0] v14;
    logic [VEL_W-1:0]        av;
    logic [VEL_W-1:0]        dl;
    logic signed [P_W-1:0]   p;
    logic signed [P_W-1:0]   hi;
    logic signed [P_W-1:0]   rr;
    logic signed [VEL_W:0]   vn;
    logic signed [FORCE_W-1:0] vs;
    axis_t                   res;
    v14 = v[VEL_W-1:0];
    av  = v14[VEL_W-1] ? VEL_W'(-v14) : v14;
    dl  = (av + VEL_W'(8)) >> 4;
    hi  = $signed(P_W'({dim, 4'b0000}));
    rr  = $signed(P_W'(r));
    if (v14[VEL_W-1]) begin
      p = $signed(P_W'(pos)) - $signed(P_W'(dl));
    end else begin
      p = $signed(P_W'(pos)) + $signed(P_W'(dl));
    end
    vn      = (VEL_W + 1)'(v14);
    res.hit = HIT_NONE;
    if (p + rr >= hi) begin
      p       = hi - rr;
      vn      = -vn;
      res.hit = HIT_HIGH;
    end else if (p - rr <= 0) begin
      p       = rr;
      vn      = -vn;
      res.hit = HIT_LOW;
    end
    if (p < 0) begin
      p = '0;
    end else if (p > $signed(P_W'((1 << POS_W) - 1))) begin
      p = $signed(P_W'((1 << POS_W) - 1));
    end
    vs      = FORCE_W'(vn);
    res.pos = p[POS_W-1:0];
    res.vel = sat_vel(vs);
    return res;
  endfunction

  logic signed [FORCE_W-1:0] fx;
  logic signed [FORCE_W-1:0] fy;
  logic signed [PROD_W-1:0]  prod;
  logic signed [VW-1:0]      vx;
  logic signed [VW-1:0]      vy;
  logic [SQ_W-1:0]           s;
  logic [SQ_W-1:0]           sq_s;
  logic [REM_W-1:0]          sq_rem;
  logic [ROOT_W-1:0]         sq_root;
  logic [POS_W-1:0]          position_x;
  logic [POS_W-1:0]          position_y;
  logic signed [VEL_W-1:0]   velocity_x;
  logic signed [VEL_W-1:0]   velocity_y;

  logic signed [MUL_W-1:0]   mul_a;
  logic signed [MUL_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]  rnd;
  logic signed [VW-1:0]      dv;
  logic [ABS_W-1:0]          ax;
  logic [ABS_W-1:0]          ay;
  logic [REM_W+1:0]          sq_t;
  logic [REM_W+1:0]          sq_trial;
  logic [Q_W-1:0]            qx;
  logic [Q_W-1:0]            qy;
  logic [Q_W-1:0]            mx;
  logic [Q_W-1:0]            my;
  axis_t                     ax_x;
  axis_t                     ax_y;

  // component magnitudes
  assign ax = ABS_W'(vx[VW-1] ? -vx : vx);
  assign ay = ABS_W'(vy[VW-1] ? -vy : vy);

  // shared multiplier operand select
  always_comb begin
    case (cmd.mul_sel)
      MSEL_FY: begin
        mul_a = MUL_W'(fy);
        mul_b = $signed(MUL_W'(cfg.inverse_mass));
      end
      MSEL_AX: begin
        mul_a = $signed({1'b0, ax});
        mul_b = $signed({1'b0, ax});
      end
      MSEL_AY: begin
        mul_a = $signed({1'b0, ay});
        mul_b = $signed({1'b0, ay});
      end
      default: begin
        mul_a = MUL_W'(fx);
        mul_b = $signed(MUL_W'(cfg.inverse_mass));
      end
    endcase
  end

  // velocity change rounded to nearest, ties up
  assign rnd = prod + $signed(PROD_W'(ROUND_HALF));
  assign dv  = $signed(rnd[IM_FRAC +: VW]);

  // square root digit step
  assign sq_t     = {sq_rem, sq_s[SQ_W-1 -: 2]};
  assign sq_trial = (REM_W + 2)'({sq_root, 2'b01});

  assign sts.capped = s > SQ_W'(LIM * LIM);

  // divider lanes, scaled magnitude over the root
  pswb_div u_div_x (
    .clk      (clk),
    .init     (cmd.div_init),
    .step     (cmd.div_step),
    .dividend (D_W'(ax) * D_W'(LIM)),
    .divisor  (sq_root),
    .quot     (qx)
  );

  pswb_div u_div_y (
    .clk      (clk),
    .init     (cmd.div_init),
    .step     (cmd.div_step),
    .dividend (D_W'(ay) * D_W'(LIM)),
    .divisor  (sq_root),
    .quot     (qy)
  );

  assign mx = (qx > Q_W'(LIM)) ? Q_W'(LIM) : qx;
  assign my = (qy > Q_W'(LIM)) ? Q_W'(LIM) : qy;

  // wall handling on both axes
  assign ax_x = wall_step(position_x, vx, cfg.arena_width, cfg.circle_radius);
  assign ax_y = wall_step(position_y, vy, cfg.arena_height, cfg.circle_radius);

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      fx <= item_force_x;
      fy <= item_force_y;
    end
    if (cmd.prod_load) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.vx_load) begin
      vx <= VW'(velocity_x) + dv;
    end else if (cmd.cap_load) begin
      vx <= vx[VW-1] ? -$signed(VW'(mx)) : $signed(VW'(mx));
    end
    if (cmd.vy_load) begin
      vy <= VW'(velocity_y) + dv;
    end else if (cmd.cap_load) begin
      vy <= vy[VW-1] ? -$signed(VW'(my)) : $signed(VW'(my));
    end
    if (cmd.s_load) begin
      s <= $unsigned(prod);
    end else if (cmd.s_add) begin
      s <= s + $unsigned(prod);
    end
    if (cmd.sqrt_init) begin
      sq_s    <= s;
      sq_rem  <= '0;
      sq_root <= '0;
    end else if (cmd.sqrt_step) begin
      sq_s <= {sq_s[SQ_W-3:0], 2'b00};
      if (sq_t >= sq_trial) begin
        sq_rem  <= REM_W'(sq_t - sq_trial);
        sq_root <= {sq_root[ROOT_W-2:0], 1'b1};
      end else begin
        sq_rem  <= sq_t[REM_W-1:0];
        sq_root <= {sq_root[ROOT_W-2:0], 1'b0};
      end
    end
  end

  // particle state
  always_ff @(posedge clk) begin
    if (rst) begin
      position_x <= START_X_RST;
      position_y <= START_Y_RST;
      velocity_x <= '0;
      velocity_y <= '0;
    end else if (cmd.restart_load) begin
      position_x <= cfg.start_x;
      position_y <= cfg.start_y;
      velocity_x <= sat_vel(fx);
      velocity_y <= sat_vel(fy);
    end else if (cmd.step_commit) begin
      position_x <= ax_x.pos;
      position_y <= ax_y.pos;
      velocity_x <= ax_x.vel;
      velocity_y <= ax_y.vel;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (cmd.restart_load) begin
      pos_x <= cfg.start_x;
      pos_y <= cfg.start_y;
      vel_x <= sat_vel(fx);
      vel_y <= sat_vel(fy);
      hit_x <= HIT_NONE;
      hit_y <= HIT_NONE;
    end else if (cmd.step_commit) begin
      pos_x <= ax_x.pos;
      pos_y <= ax_y.pos;
      vel_x <= ax_x.vel;
      vel_y <= ax_y.vel;
      hit_x <= ax_x.hit;
      hit_y <= ax_y.hit;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pswb_ctrl.sv -----
// ----------------------------------------------------------------------------
// pswb_ctrl
// Controller: sequences the datapath through force scaling, speed check,
// square root, divide and position update, and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module pswb_ctrl (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       item_valid,
  input  wire logic       item_restart,
  output logic            item_ready,
  input  wire logic       out_ready,
  output logic            out_valid,
  input  wire pswb_pkg::sts_t sts,
  output pswb_pkg::cmd_t  cmd
);
  import pswb_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DVX   = 4'd1;
  localparam logic [3:0] S_DVY   = 4'd2;
  localparam logic [3:0] S_SQX   = 4'd3;
  localparam logic [3:0] S_SQY   = 4'd4;
  localparam logic [3:0] S_SUM   = 4'd5;
  localparam logic [3:0] S_CHECK = 4'd6;
  localparam logic [3:0] S_SQRT  = 4'd7;
  localparam logic [3:0] S_DIVI  = 4'd8;
  localparam logic [3:0] S_DIV   = 4'd9;
  localparam logic [3:0] S_CAP   = 4'd10;
  localparam logic [3:0] S_POS   = 4'd11;
  localparam logic [3:0] S_RLD   = 4'd12;

  logic [3:0]       state;
  logic [3:0]       state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             out_valid_next;
  logic             out_free;

  assign item_ready = (state == S_IDLE);
  assign out_free   = !out_valid || out_ready;

  // next state and datapath commands
  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    out_valid_next = out_valid;
    cmd            = '0;
    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.item_load = 1'b1;
          state_next    = item_restart ? S_RLD : S_DVX;
        end
      end
      S_DVX: begin
        cmd.mul_sel   = MSEL_FX;
        cmd.prod_load = 1'b1;
        state_next    = S_DVY;
      end
      S_DVY: begin
        cmd.vx_load   = 1'b1;
        cmd.mul_sel   = MSEL_FY;
        cmd.prod_load = 1'b1;
        state_next    = S_SQX;
      end
      S_SQX: begin
        cmd.vy_load   = 1'b1;
        cmd.mul_sel   = MSEL_AX;
        cmd.prod_load = 1'b1;
        state_next    = S_SQY;
      end
      S_SQY: begin
        cmd.s_load    = 1'b1;
        cmd.mul_sel   = MSEL_AY;
        cmd.prod_load = 1'b1;
        state_next    = S_SUM;
      end
      S_SUM: begin
        cmd.s_add  = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (sts.capped) begin
          cmd.sqrt_init = 1'b1;
          cnt_next      = CNT_W'(SQRT_STEPS - 1);
          state_next    = S_SQRT;
        end else begin
          state_next = S_POS;
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (cnt == '0) begin
          state_next = S_DIVI;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      S_DIVI: begin
        cmd.div_init = 1'b1;
        cnt_next     = CNT_W'(DIV_STEPS - 1);
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == '0) begin
          state_next = S_CAP;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      S_CAP: begin
        cmd.cap_load = 1'b1;
        state_next   = S_POS;
      end
      S_POS: begin
        if (out_free) begin
          cmd.step_commit = 1'b1;
          out_valid_next  = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_RLD: begin
        if (out_free) begin
          cmd.restart_load = 1'b1;
          out_valid_next   = 1'b1;
          state_next       = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/particle_step_wall_bounce.sv -----
// Tick: result registered after force scaling, speed check and position
// update, with square root and divide lanes between when capped; restart:
// once the output is free. One word in work at a time; the next is taken
// in the cycle after a result is registered, while that result may wait.
// Reset: registers to defaults, position to the start reset, velocity to zero.
// ----------------------------------------------------------------------------
// particle_step_wall_bounce
// One circle in a rectangular arena, advanced one Euler step per tick word,
// with a speed cap and wall bounce; top level joining config, control, datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module particle_step_wall_bounce (
  input  wire logic      clk,
  input  wire logic      rst,
  pswb_item_if.sink      item,
  pswb_result_if.source  result,
  pswb_cfg_if.sink       cfg
);
  import pswb_pkg::*;

  cfg_t regs;
  cmd_t cmd;
  sts_t sts;

  // configuration writes are always taken
  assign cfg.ready = 1'b1;

  pswb_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (regs)
  );

  pswb_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_restart (item.restart),
    .item_ready   (item.ready),
    .out_ready    (result.ready),
    .out_valid    (result.valid),
    .sts          (sts),
    .cmd          (cmd)
  );

  pswb_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg          (regs),
    .item_force_x (item.force_x),
    .item_force_y (item.force_y),
    .sts          (sts),
    .pos_x        (result.pos_x),
    .pos_y        (result.pos_y),
    .vel_x        (result.vel_x),
    .vel_y        (result.vel_y),
    .hit_x        (result.hit_x),
    .hit_y        (result.hit_y)
  );

endmodule

`default_nettype wire
